/* rtl/dsus_pkg.sv */
// Package with the request, response and state types of the dual stack with undo store.
package dsus_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH    = 2'd0,
        REQ_DISCARD = 2'd1,
        REQ_SOFTDEL = 2'd2,
        REQ_RESTORE = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_MAIN_EMPTY = 2'd1,
        STS_AUX_EMPTY  = 2'd2,
        STS_POOL_FULL  = 2'd3
    } t_status;

    localparam int unsigned COUNT_W = 9;

    typedef struct packed {
        t_req_type          req_type;
        logic signed [31:0] push_value;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic signed [31:0]   moved_value;
        logic [COUNT_W-1:0]   main_count;
        logic [COUNT_W-1:0]   aux_count;
        logic                 main_empty;
    } t_rsp;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

endpackage

/* rtl/dual_stack_with_undo_store.sv */
// Top level of the dual stack with undo store: two stack memories and their sequencer.
//
// Usage: requests arrive on the input channel (i_valid, o_ready, i_item) and each
// one yields exactly one result item on the output channel (o_valid, i_ready, o_item).
// A request pushes onto the main stack, discards the main top, moves the main top to
// the undo stack, or moves the undo top back. The two stacks share a pool of
// POOL_ENTRIES entries; a push into a full pool reports a full status and changes
// nothing.
// A request accepted at one clock edge is latched, and the top entries of both stacks
// are read into registers; the compute step then computes the result, writes the
// memories back and loads the result into the output register, which raises o_valid.
// The block takes no new item until the current one has finished its compute step,
// so reads and writes never overlap on the same entry.
// Reset: i_rst_n is synchronous and active low. It empties both stacks (the counts go
// to zero) and drops o_valid; the memory contents need no clearing.
// Stall: while a result waits in the output register the block still accepts the
// next item and reads its operands, but holds it in the compute step until the
// output register is free; o_ready stays low meanwhile.
module dual_stack_with_undo_store #(
    parameter int unsigned POOL_ENTRIES = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dsus_pkg::t_req  i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output dsus_pkg::t_rsp  o_item
);

    localparam int unsigned AW = $clog2(POOL_ENTRIES);
    localparam int unsigned CW = $clog2(POOL_ENTRIES + 1);

    // Stack memories, one synchronous read port and one write port each.
    logic [31:0] main_mem [POOL_ENTRIES];
    logic [31:0] aux_mem  [POOL_ENTRIES];

    dsus_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_main_depth, n_main_depth;
    logic [CW-1:0]    r_aux_depth, n_aux_depth;
    logic             r_out_valid, n_out_valid;
    dsus_pkg::t_req   r_req;
    dsus_pkg::t_rsp   r_out, n_out;
    logic [31:0]      r_main_rd;
    logic [31:0]      r_aux_rd;

    logic             w_accept;
    logic             w_load;
    logic [CW:0]      w_total;
    logic [AW-1:0]    w_main_rd_addr;
    logic [AW-1:0]    w_aux_rd_addr;
    logic             w_main_we;
    logic [31:0]      w_main_wdata;
    logic             w_aux_we;
    logic [CW-1:0]    w_main_dec;
    logic [CW-1:0]    w_aux_dec;
    logic [31:0]      w_main_cnt32;
    logic [31:0]      w_aux_cnt32;

    assign w_accept = i_valid && o_ready;
    // The compute step completes only when the output register can take its result.
    assign w_load   = (r_state == dsus_pkg::ST_EXEC) && (!r_out_valid || i_ready);
    assign w_total  = {1'b0, r_main_depth} + {1'b0, r_aux_depth};

    assign w_main_dec     = r_main_depth - 1'b1;
    assign w_aux_dec      = r_aux_depth - 1'b1;
    assign w_main_rd_addr = w_main_dec[AW-1:0];
    assign w_aux_rd_addr  = w_aux_dec[AW-1:0];

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dsus_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = dsus_pkg::ST_EXEC;
                end
            end
            dsus_pkg::ST_EXEC: begin
                if (w_load) begin
                    n_state = dsus_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dsus_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and datapath logic: the result of the latched request and the write-backs.
    always_comb begin
        o_ready      = (r_state == dsus_pkg::ST_IDLE);
        n_main_depth = r_main_depth;
        n_aux_depth  = r_aux_depth;
        w_main_we    = 1'b0;
        w_main_wdata = r_req.push_value;
        w_aux_we     = 1'b0;
        n_out.status      = dsus_pkg::STS_OK;
        n_out.moved_value = '0;
        case (r_req.req_type)
            dsus_pkg::REQ_PUSH: begin
                if (w_total >= (CW + 1)'(POOL_ENTRIES)) begin
                    n_out.status = dsus_pkg::STS_POOL_FULL;
                end else begin
                    w_main_we    = 1'b1;
                    w_main_wdata = r_req.push_value;
                    n_main_depth = r_main_depth + 1'b1;
                end
            end
            dsus_pkg::REQ_DISCARD: begin
                if (r_main_depth == '0) begin
                    n_out.status = dsus_pkg::STS_MAIN_EMPTY;
                end else begin
                    n_main_depth      = w_main_dec;
                    n_out.moved_value = r_main_rd;
                end
            end
            dsus_pkg::REQ_SOFTDEL: begin
                if (r_main_depth == '0) begin
                    n_out.status = dsus_pkg::STS_MAIN_EMPTY;
                end else begin
                    n_main_depth      = w_main_dec;
                    n_aux_depth       = r_aux_depth + 1'b1;
                    w_aux_we          = 1'b1;
                    n_out.moved_value = r_main_rd;
                end
            end
            dsus_pkg::REQ_RESTORE: begin
                if (r_aux_depth == '0) begin
                    n_out.status = dsus_pkg::STS_AUX_EMPTY;
                end else begin
                    n_aux_depth       = w_aux_dec;
                    n_main_depth      = r_main_depth + 1'b1;
                    w_main_we         = 1'b1;
                    w_main_wdata      = r_aux_rd;
                    n_out.moved_value = r_aux_rd;
                end
            end
            default: begin
                n_out.status = dsus_pkg::STS_OK;
            end
        endcase
        w_main_we = w_main_we && w_load;
        w_aux_we  = w_aux_we && w_load;
        // Counts are reported modulo 512 when the pool is larger than that.
        w_main_cnt32     = 32'(n_main_depth);
        w_aux_cnt32      = 32'(n_aux_depth);
        n_out.main_count = w_main_cnt32[dsus_pkg::COUNT_W-1:0];
        n_out.aux_count  = w_aux_cnt32[dsus_pkg::COUNT_W-1:0];
        n_out.main_empty = (n_main_depth == '0);

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dsus_pkg::ST_IDLE;
            r_main_depth <= '0;
            r_aux_depth  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_load) begin
                r_main_depth <= n_main_depth;
                r_aux_depth  <= n_aux_depth;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_item;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    // Memory ports. Reads happen only at acceptance and writes only in the compute
    // step, so a read never meets a write to the same entry.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_main_rd <= main_mem[w_main_rd_addr];
            r_aux_rd  <= aux_mem[w_aux_rd_addr];
        end
        if (w_main_we) begin
            main_mem[r_main_depth[AW-1:0]] <= w_main_wdata;
        end
        if (w_aux_we) begin
            aux_mem[r_aux_depth[AW-1:0]] <= r_main_rd;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // An accepted item always moves the sequencer into the compute step.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == dsus_pkg::ST_EXEC))
        else $error("accepted item did not enter the compute step");

    // The two stacks together never hold more than the pool.
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_total <= (CW + 1)'(POOL_ENTRIES))
        else $error("stack depths exceed the pool size");

    // Moves and discards never grow the combined count.
    a_move_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_req.req_type != dsus_pkg::REQ_PUSH)) |=> (w_total <= $past(w_total)))
        else $error("a non-push request grew the combined count");

    // A successful push grows the main stack by one.
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_req.req_type == dsus_pkg::REQ_PUSH)
            && (n_out.status == dsus_pkg::STS_OK))
        |=> (r_main_depth == $past(r_main_depth) + 1'b1))
        else $error("successful push did not grow the main stack");

    // A new result is loaded only when the previous one has been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> ($stable(r_out) && r_out_valid))
        else $error("pending result was overwritten");

endmodule
